// ----- src/assert_macros.svh -----
// Assertion macros shared by the decoder modules.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/uud_pkg.sv -----
package uud_pkg;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_END        = 3'd1;
    localparam logic [2:0] ST_BAD_FULL   = 3'd2;
    localparam logic [2:0] ST_BAD_FIRST  = 3'd3;
    localparam logic [2:0] ST_BAD_SECOND = 3'd4;
    localparam logic [2:0] ST_EMPTY      = 3'd5;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic [5:0] byte_count;
        logic       last;
    } result_t;

    // Results produced by one accepted beat, in order; count is 0 to 3.
    typedef struct packed {
        logic [1:0]          count;
        result_t [2:0]       item;
    } emit_t;

    function automatic result_t data_result(logic [7:0] value, logic is_last);
        result_t r;
        r.kind       = KIND_DATA;
        r.data_byte  = value;
        r.status     = ST_OK;
        r.byte_count = 6'd0;
        r.last       = is_last;
        return r;
    endfunction

endpackage

// ----- src/uud_char_if.sv -----
interface uud_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       line_done;

    modport source
    (
        output valid,
        output char_in,
        output line_done,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  char_in,
        input  line_done,
        output ready
    );
endinterface

// ----- src/uud_result_if.sv -----
interface uud_result_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic [5:0] byte_count;
    logic       last;

    modport source
    (
        output valid,
        output kind,
        output data_byte,
        output status,
        output byte_count,
        output last,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  kind,
        input  data_byte,
        input  status,
        input  byte_count,
        input  last,
        output ready
    );
endinterface

// ----- src/uud_result_fifo.sv -----
`include "assert_macros.svh"

module uud_result_fifo
    import uud_pkg::*;
#(
    parameter int unsigned DEPTH = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  emit_t   wr,
    output logic    space_ok,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    result_t           mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              pop;

    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] p, logic [1:0] k);
        logic [AW+1:0] s;
        s = {2'b00, p} + (AW + 2)'(k);
        if (s >= (AW + 2)'(DEPTH))
        begin
            s = s - (AW + 2)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign space_ok  = (count_reg <= CW'(DEPTH - 3));

    always_comb
    begin
        wr_ptr_next = wrap_add(wr_ptr_reg, wr.count);
        rd_ptr_next = pop ? wrap_add(rd_ptr_reg, 2'd1) : rd_ptr_reg;
        count_next  = count_reg + CW'(wr.count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (k < int'(wr.count))
            begin
                mem_reg[wrap_add(wr_ptr_reg, 2'(k))] <= wr.item[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH))
    `ASSERT_IMPLIES(a_write_has_room, clk, rst_n, wr.count != 2'd0, space_ok)
    `ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && wr.count == 2'd0, count_reg == $past(count_reg) - CW'(1))

endmodule

// ----- src/uud_core.sv -----
`include "assert_macros.svh"

module uud_core
    import uud_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] char_in,
    input  logic       line_done,
    output emit_t      emit
);

    typedef enum logic [1:0]
    {
        PH_LENGTH = 2'd0,
        PH_BODY   = 2'd1,
        PH_SKIP   = 2'd2
    } phase_t;

    typedef enum logic [2:0]
    {
        EM_NONE   = 3'd0,
        EM_E      = 3'd1,
        EM_EN     = 3'd2,
        EM_END    = 3'd3,
        EM_END_CR = 3'd4,
        EM_END_LF = 3'd5,
        EM_FAIL   = 3'd6
    } end_match_t;

    localparam logic [7:0] CH_E  = 8'h65;
    localparam logic [7:0] CH_N  = 8'h6E;
    localparam logic [7:0] CH_D  = 8'h64;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LO = 8'h20;
    localparam logic [7:0] CH_HI = 8'h60;

    phase_t          phase_reg;
    phase_t          phase_next;
    end_match_t      end_reg;
    end_match_t      end_next;
    logic [5:0]      bytes_left_reg;
    logic [5:0]      bytes_left_next;
    logic [5:0]      line_length_reg;
    logic [5:0]      line_length_next;
    logic [1:0]      group_pos_reg;
    logic [1:0]      group_pos_next;
    logic [2:0][5:0] held_reg;
    logic [2:0][5:0] held_next;
    logic [2:0]      error_reg;
    logic [2:0]      error_next;

    logic [5:0]      sx;
    logic            char_ok;
    logic [2:0]      line_status;
    logic [5:0]      line_count;

    assign sx      = char_in[5:0] - 6'd32;
    assign char_ok = (char_in >= CH_LO) && (char_in <= CH_HI);

    always_comb
    begin
        line_count = 6'd0;
        if (end_reg == EM_END || end_reg == EM_END_LF)
        begin
            line_status = ST_END;
        end
        else if (phase_reg == PH_LENGTH)
        begin
            line_status = ST_EMPTY;
        end
        else if (error_reg != ST_OK)
        begin
            line_status = error_reg;
        end
        else if (bytes_left_reg >= 6'd3)
        begin
            line_status = ST_BAD_FULL;
        end
        else if (bytes_left_reg == 6'd2)
        begin
            line_status = (group_pos_reg >= 2'd2) ? ST_BAD_SECOND : ST_BAD_FIRST;
        end
        else if (bytes_left_reg == 6'd1)
        begin
            line_status = ST_BAD_FIRST;
        end
        else
        begin
            line_status = ST_OK;
            line_count  = line_length_reg;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        end_next         = end_reg;
        bytes_left_next  = bytes_left_reg;
        line_length_next = line_length_reg;
        group_pos_next   = group_pos_reg;
        held_next        = held_reg;
        error_next       = error_reg;
        emit             = '0;

        if (take && line_done)
        begin
            emit.count              = 2'd1;
            emit.item[0].kind       = KIND_STATUS;
            emit.item[0].data_byte  = 8'd0;
            emit.item[0].status     = line_status;
            emit.item[0].byte_count = line_count;
            emit.item[0].last       = 1'b1;
            phase_next       = PH_LENGTH;
            end_next         = EM_NONE;
            bytes_left_next  = 6'd0;
            line_length_next = 6'd0;
            group_pos_next   = 2'd0;
            held_next        = '0;
            error_next       = ST_OK;
        end
        else if (take)
        begin
            case (end_reg)
                EM_NONE:   end_next = (char_in == CH_E) ? EM_E : EM_FAIL;
                EM_E:      end_next = (char_in == CH_N) ? EM_EN : EM_FAIL;
                EM_EN:     end_next = (char_in == CH_D) ? EM_END : EM_FAIL;
                EM_END:    end_next = (char_in == CH_LF) ? EM_END_LF :
                                      (char_in == CH_CR) ? EM_END_CR : EM_FAIL;
                EM_END_CR: end_next = (char_in == CH_LF) ? EM_END_LF : EM_FAIL;
                default:   end_next = EM_FAIL;
            endcase

            case (phase_reg)
                PH_LENGTH:
                begin
                    line_length_next = sx;
                    bytes_left_next  = sx;
                    group_pos_next   = 2'd0;
                    phase_next       = (sx == 6'd0) ? PH_SKIP : PH_BODY;
                end
                PH_BODY:
                begin
                    if (bytes_left_reg >= 6'd3)
                    begin
                        if (!char_ok)
                        begin
                            error_next = ST_BAD_FULL;
                            phase_next = PH_SKIP;
                        end
                        else if (group_pos_reg != 2'd3)
                        begin
                            held_next[group_pos_reg] = sx;
                            group_pos_next           = group_pos_reg + 2'd1;
                        end
                        else
                        begin
                            emit.count   = 2'd3;
                            emit.item[0] = data_result({held_reg[0], held_reg[1][5:4]}, 1'b0);
                            emit.item[1] = data_result({held_reg[1][3:0], held_reg[2][5:2]},
                                                       1'b0);
                            emit.item[2] = data_result({held_reg[2][1:0], sx}, 1'b1);
                            group_pos_next  = 2'd0;
                            bytes_left_next = bytes_left_reg - 6'd3;
                        end
                    end
                    else if (group_pos_reg < 2'd2)
                    begin
                        if (!char_ok)
                        begin
                            error_next = ST_BAD_FIRST;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            held_next[group_pos_reg] = sx;
                            group_pos_next           = group_pos_reg + 2'd1;
                            if (group_pos_reg == 2'd1)
                            begin
                                emit.count      = 2'd1;
                                emit.item[0]    = data_result({held_reg[0], sx[5:4]}, 1'b1);
                                bytes_left_next = bytes_left_reg - 6'd1;
                            end
                        end
                    end
                    else
                    begin
                        if (!char_ok)
                        begin
                            error_next = ST_BAD_SECOND;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            emit.count      = 2'd1;
                            emit.item[0]    = data_result({held_reg[1][3:0], sx[5:2]}, 1'b1);
                            group_pos_next  = 2'd3;
                            bytes_left_next = bytes_left_reg - 6'd1;
                        end
                    end
                    if (bytes_left_next == 6'd0)
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LENGTH;
            end_reg         <= EM_NONE;
            bytes_left_reg  <= 6'd0;
            line_length_reg <= 6'd0;
            group_pos_reg   <= 2'd0;
            held_reg        <= '0;
            error_reg       <= ST_OK;
        end
        else
        begin
            phase_reg       <= phase_next;
            end_reg         <= end_next;
            bytes_left_reg  <= bytes_left_next;
            line_length_reg <= line_length_next;
            group_pos_reg   <= group_pos_next;
            held_reg        <= held_next;
            error_reg       <= error_next;
        end
    end

    `ASSERT_ALWAYS(a_left_within_length, clk, rst_n, bytes_left_reg <= line_length_reg)
    `ASSERT_NEXT(a_line_restart, clk, rst_n, take && line_done, phase_reg == PH_LENGTH && bytes_left_reg == 6'd0 && error_reg == ST_OK)
    `ASSERT_IMPLIES(a_status_alone, clk, rst_n, emit.count != 2'd0 && emit.item[0].kind == KIND_STATUS, emit.count == 2'd1)

endmodule

// ----- src/uudecode_line_decoder.sv -----
// Channel   Dir   Payload                                       Beat
// chars     in    char_in[7:0], line_done                       one character or end of line
// results   out   kind, data_byte[7:0], status[2:0],            one decoded byte or line status
//                 byte_count[5:0], last
//
// One character is accepted per cycle while the result buffer has room for three results.
// A beat's results are visible from the next cycle and leave one per cycle while results.ready is high.
// A full group of four characters queues three bytes at once; the buffer depth sets how
// long the output may stall before chars.ready drops.
// Reset clears the line state and empties the result buffer.
module uudecode_line_decoder
    import uud_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    uud_char_if.sink      chars,
    uud_result_if.source  results
);

    logic    take;
    logic    space_ok;
    emit_t   emit;
    result_t head;

    assign chars.ready = space_ok;
    assign take        = chars.valid && space_ok;

    uud_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .char_in   (chars.char_in),
        .line_done (chars.line_done),
        .emit      (emit)
    );

    uud_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (emit),
        .space_ok  (space_ok),
        .out_valid (results.valid),
        .out_data  (head),
        .out_ready (results.ready)
    );

    assign results.kind       = head.kind;
    assign results.data_byte  = head.data_byte;
    assign results.status     = head.status;
    assign results.byte_count = head.byte_count;
    assign results.last       = head.last;

endmodule
